[rtl/fcsu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fcsu_pkg;

  localparam int RegCount = 48;
  localparam logic [15:0] SampleIntervalReset = 16'd95;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [5:0] STATUS = 6'h16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sample_valid;
    logic [3:0] pulse_one_level;
    logic [3:0] pulse_two_level;
    logic [3:0] wave_level;
    logic [3:0] noise_level;
    logic [7:0] panning;
    logic [7:0] master_volume;
  } out_item_t;

  function automatic logic [7:0] power_value(input logic [5:0] a);
    logic [7:0] v;
    begin
      case (a)
        6'h00: v = 8'h80; 6'h01: v = 8'hbf; 6'h02: v = 8'hf3; 6'h03: v = 8'hff;
        6'h04: v = 8'hbf; 6'h05: v = 8'hff; 6'h06: v = 8'h3f; 6'h07: v = 8'h00;
        6'h08: v = 8'hff; 6'h09: v = 8'hbf; 6'h0a: v = 8'h7f; 6'h0b: v = 8'hff;
        6'h0c: v = 8'h9f; 6'h0d: v = 8'hff; 6'h0e: v = 8'hbf; 6'h0f: v = 8'hff;
        6'h10: v = 8'hff; 6'h11: v = 8'h00; 6'h12: v = 8'h00; 6'h13: v = 8'hbf;
        6'h14: v = 8'h77; 6'h15: v = 8'hf3; 6'h16: v = 8'hf1;
        default: v = 8'hff;
      endcase
      return v;
    end
  endfunction

  function automatic logic [7:0] duty_pattern(input logic [1:0] d);
    logic [7:0] v;
    begin
      case (d)
        2'd0: v = 8'hfe;
        2'd1: v = 8'h7e;
        2'd2: v = 8'h78;
        default: v = 8'h81;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/fcsu_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module fcsu_engine (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   go,
  input  wire fcsu_pkg::in_item_t item,
  input  wire  [15:0]           sample_interval,
  output fcsu_pkg::out_item_t   result
);

  localparam int STATUS_IDX = 22;

  // register file and channel state
  logic [7:0]  rf [48];
  logic [10:0] wper [3];
  logic [10:0] aper [3];
  logic [11:0] pcnt [3];
  logic [2:0]  duty [2];
  logic [4:0]  wpos;
  logic [7:0]  elat [3];
  logic [3:0]  evol [3];
  logic [16:0] ediv [3];
  logic [2:0]  estep [3];
  logic [8:0]  lcnt [4];
  logic [14:0] ldiv [4];
  logic [2:0]  spl;
  logic [15:0] sdiv;
  logic [2:0]  sstep;
  logic        sact;
  logic [15:0] nsh;
  logic [22:0] ndiv;
  logic [21:0] nrel;
  logic [16:0] scnt;

  logic [7:0]  rf_next [48];
  logic [10:0] wper_next [3];
  logic [10:0] aper_next [3];
  logic [11:0] pcnt_next [3];
  logic [2:0]  duty_next [2];
  logic [4:0]  wpos_next;
  logic [7:0]  elat_next [3];
  logic [3:0]  evol_next [3];
  logic [16:0] ediv_next [3];
  logic [2:0]  estep_next [3];
  logic [8:0]  lcnt_next [4];
  logic [14:0] ldiv_next [4];
  logic [2:0]  spl_next;
  logic [15:0] sdiv_next;
  logic [2:0]  sstep_next;
  logic        sact_next;
  logic [15:0] nsh_next;
  logic [22:0] ndiv_next;
  logic [21:0] nrel_next;
  logic [16:0] scnt_next;
  fcsu_pkg::out_item_t res_next;

  // sweep helper: returns next period and overflow flag
  function automatic logic [11:0] sweep_calc(input logic [10:0] cur, input logic [7:0] r0);
    logic [10:0] d;
    logic [11:0] n;
    logic        ovf;
    begin
      d = cur >> r0[2:0];
      ovf = 1'b0;
      if (r0[3]) begin
        n = {1'b0, cur} - {1'b0, d};
      end else begin
        n = {1'b0, cur} + {1'b0, d};
        ovf = n[11];
      end
      if (n[11]) n = {1'b0, cur};
      return {ovf, n[10:0]};
    end
  endfunction

  always_comb begin
    logic [5:0]  a;
    logic [7:0]  v;
    logic [7:0]  st;
    logic [11:0] sw;
    logic [11:0] sw2;
    logic [16:0] cyc;
    logic        b;
    logic [15:0] s;
    logic [21:0] base;
    logic [3:0]  idx;
    logic [7:0]  wb;
    logic [7:0]  dp1;
    logic [7:0]  dp2;
    logic [18:0] pc;
    logic [17:0] ed;
    logic [15:0] ld;
    logic [16:0] sd;
    logic [23:0] nd;
    logic [17:0] sc;
    int          k;
    for (k = 0; k < 48; k++) rf_next[k] = rf[k];
    for (k = 0; k < 3; k++) begin
      wper_next[k] = wper[k]; aper_next[k] = aper[k]; pcnt_next[k] = pcnt[k];
      elat_next[k] = elat[k]; evol_next[k] = evol[k]; ediv_next[k] = ediv[k];
      estep_next[k] = estep[k];
    end
    for (k = 0; k < 4; k++) begin
      lcnt_next[k] = lcnt[k]; ldiv_next[k] = ldiv[k];
    end
    duty_next[0] = duty[0]; duty_next[1] = duty[1];
    wpos_next = wpos; spl_next = spl; sdiv_next = sdiv; sstep_next = sstep;
    sact_next = sact; nsh_next = nsh; ndiv_next = ndiv; nrel_next = nrel;
    scnt_next = scnt;
    res_next = '0;
    a = item.reg_offset;
    v = item.write_data;
    cyc = {9'd0, item.cycles};
    sw = '0; sw2 = '0; b = 1'b0; s = '0; base = '0; idx = '0; wb = '0;
    dp1 = '0; dp2 = '0;
    pc = '0; ed = '0; ld = '0; sd = '0; nd = '0; sc = '0;
    st = rf[STATUS_IDX];

    if (item.req_type == fcsu_pkg::REQ_READ) begin
      if (a >= 6'd48 || (a >= 6'd32 && st[2])) res_next.read_data = 8'hff;
      else res_next.read_data = rf[a];
    end else if (item.req_type == fcsu_pkg::REQ_WRITE) begin
      if (a == fcsu_pkg::STATUS) begin
        if (st[7] && !v[7]) begin
          // power down
          rf_next[STATUS_IDX] = st & 8'h70;
          rf_next[6'h15] = 8'h00; rf_next[6'h14] = 8'h00;
          for (k = 0; k < 3; k++) begin
            wper_next[k] = '0; aper_next[k] = '0; pcnt_next[k] = '0;
            elat_next[k] = '0; evol_next[k] = '0; ediv_next[k] = '0;
            estep_next[k] = '0;
          end
          for (k = 0; k < 4; k++) begin
            lcnt_next[k] = 9'd63; ldiv_next[k] = '0;
          end
          lcnt_next[2] = 9'd255;
          duty_next[0] = '0; duty_next[1] = '0; wpos_next = '0;
          spl_next = '0; sdiv_next = '0; sstep_next = '0; sact_next = 1'b0;
          ndiv_next = '0; nrel_next = '0; nsh_next = '0;
          rf_next[0] = rf[0] & 8'h80; rf_next[1] = rf[1] & 8'h3f;
          rf_next[2] = 8'h00; rf_next[4] = rf[4] & 8'hbf;
          rf_next[6] = rf[6] & 8'h3f; rf_next[7] = 8'h00;
          rf_next[9] = rf[9] & 8'hbf; rf_next[10] = rf[10] & 8'h7f;
          rf_next[12] = rf[12] & 8'h9f; rf_next[14] = rf[14] & 8'hbf;
          rf_next[17] = 8'h00; rf_next[18] = 8'h00;
          rf_next[19] = rf[19] & 8'hbf;
        end
        rf_next[STATUS_IDX] = {v[7], rf_next[STATUS_IDX][6:0]};
      end else if (a >= 6'd32) begin
        if (a < 6'd48 && !st[2]) rf_next[a] = v;
      end else if (st[7]) begin
        case (a)
          6'h12, 6'h14, 6'h15: rf_next[a] = v;
          6'h00: rf_next[0] = {rf[0][7], v[6:0]};
          6'h01: begin
            rf_next[1] = {v[7:6], rf[1][5:0]}; lcnt_next[0] = {3'd0, v[5:0]};
          end
          6'h06: begin
            rf_next[6] = {v[7:6], rf[6][5:0]}; lcnt_next[1] = {3'd0, v[5:0]};
          end
          6'h02: begin
            if (v[7:3] == 5'd0) rf_next[STATUS_IDX][0] = 1'b0;
            rf_next[2] = v;
          end
          6'h07: begin
            if (v[7:3] == 5'd0) rf_next[STATUS_IDX][1] = 1'b0;
            rf_next[7] = v;
          end
          6'h11: begin
            if (v[7:3] == 5'd0) rf_next[STATUS_IDX][3] = 1'b0;
            rf_next[17] = v;
          end
          6'h03: wper_next[0] = {wper[0][10:8], v};
          6'h08: wper_next[1] = {wper[1][10:8], v};
          6'h0d: wper_next[2] = {wper[2][10:8], v};
          6'h04: begin
            wper_next[0] = {v[2:0], wper[0][7:0]};
            rf_next[4] = {rf[4][7], v[6], rf[4][5:0]};
            if (v[7]) begin
              aper_next[0] = wper_next[0];
              pcnt_next[0] = {1'b0, wper_next[0]};
              duty_next[0] = '0;
              elat_next[0] = rf[2]; ediv_next[0] = '0; estep_next[0] = '0;
              evol_next[0] = rf[2][7:4];
              if (rf[2][7:3] != 5'd0) rf_next[STATUS_IDX][0] = 1'b1;
              if (lcnt[0] > 9'd63) begin
                lcnt_next[0] = '0; ldiv_next[0] = '0;
              end
              sdiv_next = '0; sstep_next = '0;
              spl_next = rf[0][6:4];
              sact_next = (rf[0][6:4] != 3'd0) || (rf[0][2:0] != 3'd0);
              if (rf[0][2:0] != 3'd0) begin
                sw = sweep_calc(wper_next[0], rf[0]);
                if (sw[11]) rf_next[STATUS_IDX][0] = 1'b0;
              end
            end
          end
          6'h09: begin
            wper_next[1] = {v[2:0], wper[1][7:0]};
            rf_next[9] = {rf[9][7], v[6], rf[9][5:0]};
            if (v[7]) begin
              aper_next[1] = wper_next[1];
              pcnt_next[1] = {1'b0, wper_next[1]};
              duty_next[1] = '0;
              elat_next[1] = rf[7]; ediv_next[1] = '0; estep_next[1] = '0;
              evol_next[1] = rf[7][7:4];
              if (rf[7][7:3] != 5'd0) rf_next[STATUS_IDX][1] = 1'b1;
              if (lcnt[1] > 9'd63) begin
                lcnt_next[1] = '0; ldiv_next[1] = '0;
              end
            end
          end
          6'h0e: begin
            wper_next[2] = {v[2:0], wper[2][7:0]};
            rf_next[14] = {rf[14][7], v[6], rf[14][5:0]};
            if (v[7]) begin
              aper_next[2] = wper_next[2];
              pcnt_next[2] = {1'b0, wper_next[2]};
              wpos_next = '0;
              if (rf[10][7]) rf_next[STATUS_IDX][2] = 1'b1;
              if (lcnt[2] > 9'd255) begin
                lcnt_next[2] = '0; ldiv_next[2] = '0;
              end
            end
          end
          6'h13: begin
            rf_next[19] = {rf[19][7], v[6], rf[19][5:0]};
            if (v[7]) begin
              elat_next[2] = rf[17]; ediv_next[2] = '0; estep_next[2] = '0;
              evol_next[2] = rf[17][7:4];
              if (rf[17][7:3] != 5'd0) rf_next[STATUS_IDX][3] = 1'b1;
              if (lcnt[3] > 9'd63) begin
                lcnt_next[3] = '0; ldiv_next[3] = '0;
              end
              nsh_next = 16'h7fff;
            end
          end
          6'h0a: begin
            rf_next[10] = {v[7], rf[10][6:0]};
            if (!v[7]) rf_next[STATUS_IDX][2] = 1'b0;
          end
          6'h0b: lcnt_next[2] = {1'b0, v};
          6'h0c: rf_next[12] = {rf[12][7], v[6:5], rf[12][4:0]};
          6'h10: lcnt_next[3] = {3'd0, v[5:0]};
          default: ;
        endcase
      end
    end else if (item.req_type == fcsu_pkg::REQ_TICK) begin
      sc = {1'b0, scnt} + {1'b0, cyc};
      if (sc >= {2'd0, sample_interval}) begin
        scnt_next = '0;
        res_next.sample_valid = 1'b1;
        dp1 = fcsu_pkg::duty_pattern(rf[1][7:6]);
        dp2 = fcsu_pkg::duty_pattern(rf[6][7:6]);
        if (st[0] && dp1[3'd7 - duty[0]])
          res_next.pulse_one_level = evol[0];
        if (st[1] && dp2[3'd7 - duty[1]])
          res_next.pulse_two_level = evol[1];
        if (st[2] && rf[12][6:5] != 2'd0) begin
          idx = wpos[4:1];
          wb = rf[{2'b10, idx}];
          res_next.wave_level = wpos[0] ? wb[3:0] : wb[7:4];
        end
        if (st[3] && nsh[0]) res_next.noise_level = evol[2];
        res_next.panning = rf[21];
        res_next.master_volume = rf[20];
      end else begin
        scnt_next = sc[16:0];
      end
      if (st[7]) begin
        // pulse channels
        for (k = 0; k < 2; k++) begin
          if (st[k]) begin
            pc = {7'd0, pcnt[k]} + {13'd0, cyc[7:2]};
            pcnt_next[k] = pc[11:0];
            if (pc[11:0] > 12'd2047) begin
              duty_next[k] = duty[k] + 3'd1;
              if (duty[k] == 3'd7) aper_next[k] = wper[k];
              pcnt_next[k] = {1'b0, (duty[k] == 3'd7) ? wper[k] : aper[k]};
            end
          end
        end
        // envelopes: pulse one, pulse two, noise
        for (k = 0; k < 3; k++) begin
          if (st[(k == 2) ? 3 : k] && elat[k][2:0] != 3'd0) begin
            ed = {1'b0, ediv[k]} + {1'b0, cyc};
            ediv_next[k] = ed[16:0];
            if (ed > 18'd65535) begin
              ediv_next[k] = ed[16:0] - 17'd65536;
              if (estep[k] + 3'd1 >= elat[k][2:0]) begin
                estep_next[k] = '0;
                if (elat[k][3]) begin
                  if (evol[k] != 4'd15) evol_next[k] = evol[k] + 4'd1;
                end else if (evol[k] != 4'd0) begin
                  evol_next[k] = evol[k] - 4'd1;
                end
              end else begin
                estep_next[k] = estep[k] + 3'd1;
              end
            end
          end
        end
        // length counters
        for (k = 0; k < 4; k++) begin
          if (st[k] && rf[(k == 0) ? 4 : (k == 1) ? 9 : (k == 2) ? 14 : 19][6]) begin
            ld = {1'b0, ldiv[k]} + cyc[15:0];
            ldiv_next[k] = ld[14:0];
            if (ld > 16'd16383) begin
              ldiv_next[k] = ld[14:0] - 15'd16384;
              lcnt_next[k] = lcnt[k] + 9'd1;
              if (lcnt_next[k] >= ((k == 2) ? 9'd255 : 9'd63))
                rf_next[STATUS_IDX][k] = 1'b0;
            end
          end
        end
        // sweep works on the period left by this tick's duty step
        if (st[0]) begin
          sd = {1'b0, sdiv} + cyc;
          sdiv_next = sd[15:0];
          if (sd > 17'd32767) begin
            sdiv_next = sd[15:0] - 16'd32768;
            if (spl != 3'd0 && sact) begin
              if (sstep + 3'd1 >= spl) begin
                sstep_next = '0;
                spl_next = rf[0][6:4];
                sw = sweep_calc(aper_next[0], rf[0]);
                sw2 = sweep_calc(sw[10:0], rf[0]);
                wper_next[0] = sw[10:0];
                aper_next[0] = sw[10:0];
                if (sw[11] || sw2[11]) rf_next[STATUS_IDX][0] = 1'b0;
              end else begin
                sstep_next = sstep + 3'd1;
              end
            end
          end
        end
        // wave
        if (st[2]) begin
          pc = {7'd0, pcnt[2]} + {12'd0, cyc[7:1]};
          pcnt_next[2] = pc[11:0];
          if (pc[11:0] > 12'd2047) begin
            wpos_next = wpos + 5'd1;
            if (wpos == 5'd31) aper_next[2] = wper[2];
            pcnt_next[2] = {1'b0, (wpos == 5'd31) ? wper[2] : aper[2]};
          end
        end
        // noise
        if (st[3]) begin
          nd = {1'b0, ndiv} + {7'd0, cyc};
          ndiv_next = nd[22:0];
          if (nd > {2'd0, nrel}) begin
            ndiv_next = '0;
            b = nsh[0] ^ nsh[1];
            s = {b, nsh[14:0]};
            if (rf[18][3]) s[7] = b;
            nsh_next = {1'b0, s[15:1]};
            base = (rf[18][2:0] == 3'd0) ? 22'd8 : {15'd0, rf[18][2:0], 4'd0};
            nrel_next = base << rf[18][7:4];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 48; k++) rf[k] <= fcsu_pkg::power_value(6'(k));
      wper[0] <= '0; wper[1] <= 11'h7ff; wper[2] <= 11'h7ff;
      aper[0] <= '0; aper[1] <= 11'h7ff; aper[2] <= 11'h7ff;
      pcnt[0] <= '0; pcnt[1] <= 12'h7ff; pcnt[2] <= 12'h7ff;
      elat[0] <= 8'd243; elat[1] <= '0; elat[2] <= '0;
      evol[0] <= 4'd15; evol[1] <= '0; evol[2] <= '0;
      for (int k = 0; k < 3; k++) begin
        ediv[k] <= '0; estep[k] <= '0;
      end
      lcnt[0] <= '0; lcnt[1] <= 9'd63; lcnt[2] <= 9'd255; lcnt[3] <= 9'd63;
      for (int k = 0; k < 4; k++) ldiv[k] <= '0;
      duty[0] <= '0; duty[1] <= '0; wpos <= '0;
      spl <= '0; sdiv <= '0; sstep <= '0; sact <= 1'b1;
      nsh <= 16'h7fff; ndiv <= '0; nrel <= '0; scnt <= '0;
    end else if (go) begin
      for (int k = 0; k < 48; k++) rf[k] <= rf_next[k];
      for (int k = 0; k < 3; k++) begin
        wper[k] <= wper_next[k]; aper[k] <= aper_next[k]; pcnt[k] <= pcnt_next[k];
        elat[k] <= elat_next[k]; evol[k] <= evol_next[k]; ediv[k] <= ediv_next[k];
        estep[k] <= estep_next[k];
      end
      for (int k = 0; k < 4; k++) begin
        lcnt[k] <= lcnt_next[k]; ldiv[k] <= ldiv_next[k];
      end
      duty[0] <= duty_next[0]; duty[1] <= duty_next[1]; wpos <= wpos_next;
      spl <= spl_next; sdiv <= sdiv_next; sstep <= sstep_next; sact <= sact_next;
      nsh <= nsh_next; ndiv <= ndiv_next; nrel <= nrel_next; scnt <= scnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) result <= res_next;
  end

endmodule
`default_nettype wire

[rtl/four_channel_sound_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                              | transaction when
// ----------+--------------------------------------+---------------------------
// request   | in_valid, in_stall, in_item          | in_valid & !in_stall
// result    | out_valid, out_stall, out_item       | out_valid & !out_stall
// config    | cfg_write, cfg_data                  | cfg_write
//
// each request is processed in a single pass between the input register and
// the result register
// a new request is taken every cycle while the output register drains
// synchronous active-high reset restores the power-on register table
// out_stall holds the result; in_stall rises only when both stages are full
module four_channel_sound_unit_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire fcsu_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output fcsu_pkg::out_item_t  out_item,
  input  wire                  cfg_write,
  input  wire  [15:0]          cfg_data
);

  logic [15:0]        sample_interval;
  fcsu_pkg::in_item_t req;
  logic               req_valid;
  logic               go;
  logic               adv;

  // input register advances when the result register is free
  assign adv      = !out_valid || !out_stall;
  assign go       = req_valid && adv;
  assign in_stall = req_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= fcsu_pkg::SampleIntervalReset;
    end else if (cfg_write) begin
      sample_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) req <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= req_valid;
    end
  end

  fcsu_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .item            (req),
    .sample_interval (sample_interval),
    .result          (out_item)
  );

endmodule
`default_nettype wire

[rtl/fcsu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module fcsu_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire fcsu_pkg::out_item_t out_item
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed under stall");

  // no input stall without a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // noise level, panning and master volume are zero when no sample set
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.sample_valid |-> out_item.panning == 8'd0 &&
      out_item.master_volume == 8'd0 && out_item.noise_level == 4'd0)
    else $error("sample fields without sample");

  // samples never carry read data
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sample_valid |-> out_item.read_data == 8'd0)
    else $error("read data on sample result");

endmodule

bind four_channel_sound_unit_core fcsu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
